// ----- src/isc_pkg.sv -----
// Shared constants, register codes and pipeline control type for the stencil filter.
package isc_pkg;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_RADIUS = 3;
  localparam int DEF_PIXEL_BITS = 16;

  localparam int MAX_HEIGHT = 4096;
  localparam int DIM_W      = 13;   // frame_width / frame_height register width
  localparam int ROW_W      = 12;   // row counter
  localparam int POS_W      = 12;   // out_row / out_col
  localparam int FILT_W     = 26;   // filtered
  localparam int STEP_W     = 8;    // Q0.8 coefficient steps
  localparam int RAD_W      = 3;    // saturated radius, MAX_RADIUS <= 7
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 13;
  localparam int FRAC_BITS  = 8;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_RADIUS   = 3'd0,
    REG_WIDTH    = 3'd1,
    REG_HEIGHT   = 3'd2,
    REG_ROW_STEP = 3'd3,
    REG_COL_STEP = 3'd4
  } isc_reg_t;

  localparam logic [1:0]        RST_RADIUS   = 2'd3;
  localparam logic [DIM_W-1:0]  RST_WIDTH    = 13'd4096;
  localparam logic [DIM_W-1:0]  RST_HEIGHT   = 13'd4096;
  localparam logic [STEP_W-1:0] RST_ROW_STEP = 8'd26;
  localparam logic [STEP_W-1:0] RST_COL_STEP = 8'd51;

  // load strobes for the arithmetic stages
  typedef struct packed {
    logic shift;    // window takes a new column
    logic ld_prod;  // product stage
    logic ld_row;   // row-sum stage
    logic ld_sum;   // output stage
  } isc_ctl_t;

endpackage

// ----- src/isc_ram.sv -----
// Generic single-write, single-read RAM with registered, read-first output.
module isc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/isc_line_buf.sv -----
// Line store: one RAM per buffered row, read as a column, row selection by age.
module isc_line_buf
  import isc_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int NLINES    = 2 * DEF_MAX_RADIUS,
  parameter int PW        = DEF_PIXEL_BITS
) (
  input  logic                         clk,
  input  logic                         acc,
  input  logic [$clog2(MAX_WIDTH)-1:0] col,
  input  logic [$clog2(NLINES)-1:0]    wr_slot,
  input  logic [PW-1:0]                wdata,
  input  logic [$clog2(NLINES)-1:0]    rd_slot,
  output logic [NLINES-1:0][PW-1:0]    taps
);

  localparam int SW = $clog2(NLINES);

  logic [PW-1:0] rdq [NLINES];

  for (genvar k = 0; k < NLINES; k++) begin : g_ram
    isc_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_ram (
      .clk   (clk),
      .we    (acc && (wr_slot == SW'(k))),
      .waddr (col),
      .wdata (wdata),
      .re    (acc),
      .raddr (col),
      .rdata (rdq[k])
    );
  end

  // taps[a-1] is the row a lines above the current one
  for (genvar a = 1; a <= NLINES; a++) begin : g_tap
    logic [SW-1:0] idx;
    assign idx = ({1'b0, rd_slot} >= (SW+1)'(a)) ? rd_slot - SW'(a)
                                                 : rd_slot + SW'(NLINES - a);
    assign taps[a-1] = rdq[idx];
  end

endmodule

// ----- src/isc_mac.sv -----
// Window registers, coefficient table, product array and registered adder tree.
module isc_mac
  import isc_pkg::*;
#(
  parameter int MAX_RADIUS = DEF_MAX_RADIUS,
  parameter int PW         = DEF_PIXEL_BITS
) (
  input  logic                            clk,
  input  isc_ctl_t                        ctl,
  input  logic [2*MAX_RADIUS:0][PW-1:0]   new_col,
  input  logic [RAD_W-1:0]                rad,
  input  logic [STEP_W-1:0]               row_step,
  input  logic [STEP_W-1:0]               col_step,
  output logic [FILT_W-1:0]               filtered
);

  localparam int SIDE   = 2 * MAX_RADIUS + 1;
  localparam int DW     = $clog2(SIDE);
  localparam int COEF_W = STEP_W + $clog2(4 * MAX_RADIUS + 1);
  localparam int PROD_W = PW + COEF_W;
  localparam int RS_W   = PROD_W + $clog2(SIDE);
  localparam int SUM_W  = RS_W + $clog2(SIDE);
  localparam int EXT_W  = SUM_W + FILT_W + FRAC_BITS;

  logic [PW-1:0]     win  [SIDE][SIDE];   // [rows back][columns back]
  logic [COEF_W-1:0] coef [SIDE][SIDE];
  logic [PROD_W-1:0] prod [SIDE][SIDE];
  logic [RS_W-1:0]   rsum [SIDE];
  logic [RS_W-1:0]   rsum_next [SIDE];
  logic [SUM_W-1:0]  total_next;
  logic [EXT_W-1:0]  ext;
  logic [DW-1:0]     span;

  assign span = DW'(2 * rad);

  always_ff @(posedge clk) begin
    for (int a = 0; a < SIDE; a++) begin
      for (int b = 0; b < SIDE; b++) begin
        if (DW'(a) <= span && DW'(b) <= span) begin
          coef[a][b] <= COEF_W'(row_step) * COEF_W'(span - DW'(a))
                      + COEF_W'(col_step) * COEF_W'(span - DW'(b));
        end else begin
          coef[a][b] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      for (int a = 0; a < SIDE; a++) begin
        for (int b = SIDE - 1; b > 0; b--) begin
          win[a][b] <= win[a][b-1];
        end
        win[a][0] <= new_col[a];
      end
    end
  end

  // taps outside the active window are forced to zero, whatever the window holds
  always_ff @(posedge clk) begin
    if (ctl.ld_prod) begin
      for (int a = 0; a < SIDE; a++) begin
        for (int b = 0; b < SIDE; b++) begin
          if (DW'(a) <= span && DW'(b) <= span) begin
            prod[a][b] <= PROD_W'(win[a][b]) * PROD_W'(coef[a][b]);
          end else begin
            prod[a][b] <= '0;
          end
        end
      end
    end
  end

  always_comb begin
    for (int a = 0; a < SIDE; a++) begin
      rsum_next[a] = '0;
      for (int b = 0; b < SIDE; b++) begin
        rsum_next[a] = rsum_next[a] + RS_W'(prod[a][b]);
      end
    end
    total_next = '0;
    for (int a = 0; a < SIDE; a++) begin
      total_next = total_next + SUM_W'(rsum[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_row) begin
      rsum <= rsum_next;
    end
  end

  assign ext = EXT_W'(total_next);

  always_ff @(posedge clk) begin
    if (ctl.ld_sum) begin
      filtered <= ext[FRAC_BITS +: FILT_W];
    end
  end

endmodule

// ----- src/image_stencil_convolution.sv -----
// Top level: 2-D stencil filter over a raster pixel stream with line RAMs.
// Stages: a pixel's result passes s1 to s5, and m_tvalid is the s5 valid.
// Throughput: one pixel per cycle unless m_tready stalls; line RAMs are read and
//   written in the same cycle at the current column; no pixel waits on another.
// Border pixels give no result; only interior centers are emitted.
// Reset (rst, synchronous): counters and stage valids clear, registers take
//   radius 3, 4096 x 4096, steps 26 / 51; line RAM contents stay as they are.
module image_stencil_convolution
  import isc_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  // config write port
  input  logic                           cfg_we,
  input  logic [CFG_ADDR_W-1:0]          cfg_addr,
  input  logic [CFG_DATA_W-1:0]          cfg_wdata,
  // pixel requests
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [((PIXEL_BITS+7)/8)*8-1:0] s_tdata,  // [PIXEL_BITS-1:0] pixel
  // filtered results
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [55:0]                    m_tdata,   // filtered, out_row, out_col
  output logic                           m_tlast    // frame_last
);

  localparam int NLINES = 2 * MAX_RADIUS;
  localparam int SIDE   = 2 * MAX_RADIUS + 1;
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int WW     = CW + 1;
  localparam int SW     = $clog2(NLINES);
  localparam int HW     = ROW_W + 1;

  typedef struct packed {
    logic             emit;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } tag_t;

  // configuration registers
  logic [1:0]        radius;
  logic [DIM_W-1:0]  frame_width;
  logic [DIM_W-1:0]  frame_height;
  logic [STEP_W-1:0] row_coef_step;
  logic [STEP_W-1:0] col_coef_step;

  // position of the next pixel
  logic [CW-1:0]     col_cnt;
  logic [ROW_W-1:0]  row_cnt;
  logic [SW-1:0]     slot;

  logic [RAD_W-1:0]  rad;
  logic [WW-1:0]     w_eff;
  logic [HW-1:0]     h_eff;
  logic              col_end, row_end, acc, cfg_hit;
  tag_t              tag_in;

  // pipeline: s1 line RAM read, s2 window, s3 products, s4 row sums, s5 output
  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  tag_t t1, t2, t3, t4, t5;
  logic [SW-1:0]         slot1;
  logic [PIXEL_BITS-1:0] pix1;

  logic [NLINES-1:0][PIXEL_BITS-1:0] taps;
  logic [SIDE-1:0][PIXEL_BITS-1:0]   new_col;
  logic [FILT_W-1:0]                 filtered;
  isc_ctl_t                          ctl;

  // saturate configuration to what the datapath holds
  assign rad = ({1'b0, radius} > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS)
                                                    : RAD_W'(radius);
  always_comb begin
    if (frame_width == '0) begin
      w_eff = WW'(1);
    end else if ((DIM_W+1)'(frame_width) > (DIM_W+1)'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width);
    end
    if (frame_height == '0) begin
      h_eff = HW'(1);
    end else if (frame_height > DIM_W'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(frame_height);
    end
  end

  assign col_end = (WW'(col_cnt) + WW'(1)) == w_eff;
  assign row_end = (HW'(row_cnt) + HW'(1)) == h_eff;

  // ready ripples back from the output register
  assign rdy5 = !v5 || m_tready;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign s_tready = rdy1;
  assign acc = s_tvalid && rdy1;

  assign cfg_hit = cfg_we && (cfg_addr <= REG_COL_STEP);

  always_ff @(posedge clk) begin
    if (rst) begin
      radius        <= RST_RADIUS;
      frame_width   <= RST_WIDTH;
      frame_height  <= RST_HEIGHT;
      row_coef_step <= RST_ROW_STEP;
      col_coef_step <= RST_COL_STEP;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_RADIUS:   radius        <= cfg_wdata[1:0];
        REG_WIDTH:    frame_width   <= cfg_wdata;
        REG_HEIGHT:   frame_height  <= cfg_wdata;
        REG_ROW_STEP: row_coef_step <= cfg_wdata[STEP_W-1:0];
        REG_COL_STEP: col_coef_step <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // raster counters; a config write to a known register restarts the frame
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      col_cnt <= '0;
      row_cnt <= '0;
      slot    <= '0;
    end else if (acc) begin
      if (col_end) begin
        col_cnt <= '0;
        if (row_end) begin
          row_cnt <= '0;
          slot    <= '0;
        end else begin
          row_cnt <= row_cnt + ROW_W'(1);
          slot    <= (slot == SW'(NLINES - 1)) ? '0 : slot + SW'(1);
        end
      end else begin
        col_cnt <= col_cnt + CW'(1);
      end
    end
  end

  // result tag for the pixel being accepted
  always_comb begin
    tag_in.emit = ((ROW_W+1)'(row_cnt) >= (ROW_W+1)'(2 * rad))
               && ((CW+1)'(col_cnt) >= (CW+1)'(2 * rad));
    tag_in.row  = POS_W'(row_cnt - ROW_W'(rad));
    tag_in.col  = POS_W'(col_cnt - CW'(rad));
    tag_in.last = row_end && col_end;
  end

  isc_line_buf #(.MAX_WIDTH(MAX_WIDTH), .NLINES(NLINES), .PW(PIXEL_BITS)) u_lines (
    .clk     (clk),
    .acc     (acc),
    .col     (col_cnt),
    .wr_slot (slot),
    .wdata   (s_tdata[PIXEL_BITS-1:0]),
    .rd_slot (slot1),
    .taps    (taps)
  );

  assign new_col = {taps, pix1};

  // valids and tags; s2 only stays valid for pixels that produce a result
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1 && t1.emit;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      t1    <= tag_in;
      slot1 <= slot;
      pix1  <= s_tdata[PIXEL_BITS-1:0];
    end
    if (rdy2) t2 <= t1;
    if (rdy3) t3 <= t2;
    if (rdy4) t4 <= t3;
    if (rdy5) t5 <= t4;
  end

  assign ctl.shift   = v1 && rdy2;
  assign ctl.ld_prod = rdy3;
  assign ctl.ld_row  = rdy4;
  assign ctl.ld_sum  = rdy5;

  isc_mac #(.MAX_RADIUS(MAX_RADIUS), .PW(PIXEL_BITS)) u_mac (
    .clk      (clk),
    .ctl      (ctl),
    .new_col  (new_col),
    .rad      (rad),
    .row_step (row_coef_step),
    .col_step (col_coef_step),
    .filtered (filtered)
  );

  assign m_tvalid = v5;
  assign m_tlast  = t5.last;
  assign m_tdata  = {6'd0, t5.col, t5.row, filtered};

endmodule

// ----- src/isc_checker.sv -----
// Port-level checks for the stencil filter, bound to the top level.
module isc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic        m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  a_rst_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  a_flow: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled with output sink ready");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with output register empty");

endmodule

bind image_stencil_convolution isc_checker u_isc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// ----- test/isc_checker.sv -----
// Checker: watches pixel and result streams, predicts filtered outputs, compares.
module isc_scoreboard
  import isc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                    s_tvalid,
  input  logic                    s_tready,
  input  logic [15:0]             s_tdata,
  input  logic                    m_tvalid,
  input  logic                    m_tready,
  input  logic [55:0]             m_tdata,
  input  logic                    m_tlast,
  output int                      fail_count,
  output int                      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NL = 6;
  localparam int SD = 7;

  typedef struct packed {
    logic [FILT_W-1:0] filtered;
    logic [11:0]       row;
    logic [11:0]       col;
    logic              last;
  } filt_res_t;

  filt_res_t expected_q[$];
  logic [15:0] lines [NL][4096];
  logic [15:0] win [SD][SD];
  int unsigned cur_row, cur_col;
  logic [1:0]  c_radius;
  logic [12:0] c_width, c_height;
  logic [7:0]  c_rstep, c_cstep;

  assign pending = expected_q.size();

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic int unsigned clampd(input logic [12:0] v);
    if (v == 0) return 1;
    if (v > 4096) return 4096;
    return v;
  endfunction

  task automatic predict_pixel(input logic [15:0] pix);
    int unsigned w, h, r, side, row, col, slot;
    logic [15:0] ncol [SD];
    logic [63:0] sum, coef;
    filt_res_t e;
    w = clampd(c_width);
    h = clampd(c_height);
    r = c_radius;
    side = 2 * r + 1;
    row = cur_row;
    col = cur_col;
    if (col >= w) col = w - 1;
    if (row >= h) row = h - 1;
    ncol[0] = pix;
    for (int a = 1; a < SD; a++) begin
      slot = (row + NL - a) % NL;
      ncol[a] = lines[slot][col];
    end
    lines[row % NL][col] = pix;
    for (int a = 0; a < SD; a++) begin
      for (int b = SD - 1; b > 0; b--) win[a][b] = win[a][b-1];
      win[a][0] = ncol[a];
    end
    if (row >= 2 * r && col >= 2 * r) begin
      sum = 0;
      for (int a = 0; a < side; a++)
        for (int b = 0; b < side; b++) begin
          coef = c_rstep * (side - 1 - a) + c_cstep * (side - 1 - b);
          sum += coef * win[a][b];
        end
      e.filtered = sum[FILT_W+7:8];
      e.row = 12'(row - r);
      e.col = 12'(col - r);
      e.last = (row == h - 1 && col == w - 1);
      expected_q.push_back(e);
    end
    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= h) row = 0;
    end
    cur_row = row;
    cur_col = col;
  endtask

  initial begin
    fail_count = 0;
    for (int a = 0; a < SD; a++) for (int b = 0; b < SD; b++) win[a][b] = '0;
  end

  always @(posedge clk) begin
    filt_res_t got, e;
    if (rst) begin
      cur_row = 0; cur_col = 0;
      c_radius = RST_RADIUS; c_width = RST_WIDTH; c_height = RST_HEIGHT;
      c_rstep = RST_ROW_STEP; c_cstep = RST_COL_STEP;
    end else begin
      if (m_tvalid && m_tready) begin
        got.filtered = m_tdata[25:0];
        got.row = m_tdata[37:26];
        got.col = m_tdata[49:38];
        got.last = m_tlast;
        if (expected_q.size() == 0) report("result with nothing expected");
        else begin
          e = expected_q.pop_front();
          if (got.filtered !== e.filtered)
            report($sformatf("filtered %0d exp %0d", got.filtered, e.filtered));
          if (got.row !== e.row) report($sformatf("out_row %0d exp %0d", got.row, e.row));
          if (got.col !== e.col) report($sformatf("out_col %0d exp %0d", got.col, e.col));
          if (got.last !== e.last)
            report($sformatf("frame_last %0b exp %0b", got.last, e.last));
        end
      end
      if (s_tvalid && s_tready) predict_pixel(s_tdata);
      if (cfg_we) begin
        case (isc_reg_t'(cfg_addr))
          REG_RADIUS:   c_radius = cfg_wdata[1:0];
          REG_WIDTH:    c_width  = cfg_wdata[12:0];
          REG_HEIGHT:   c_height = cfg_wdata[12:0];
          REG_ROW_STEP: c_rstep  = cfg_wdata[7:0];
          REG_COL_STEP: c_cstep  = cfg_wdata[7:0];
          default: ;
        endcase
        // only a known register restarts the frame
        if (cfg_addr <= REG_COL_STEP) begin
          cur_row = 0;
          cur_col = 0;
        end
      end
    end
  end
endmodule

// ----- test/tb_image_stencil_convolution.sv -----
// Testbench top: pixel stimulus, config phases, flow control and verdict.
module tb_image_stencil_convolution;
  import isc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic s_tvalid = 0, s_tready;
  logic [15:0] s_tdata = '0;
  logic m_tvalid, m_tready = 0;
  logic [55:0] m_tdata;
  logic m_tlast;
  int fail_count, pending;
  int send_idle = 0, recv_stall = 0;   // percent
  longint cycles = 0;

  always #5 clk = ~clk;

  image_stencil_convolution i_dut (.*);

  isc_scoreboard u_check (.*);

  // receiver back-pressure
  always @(posedge clk) m_tready <= ($urandom_range(99) >= recv_stall);

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // write enable stays high across back-to-back writes; setup drops it
  task automatic write_reg(input isc_reg_t idx, input int val);
    cfg_we <= 1; cfg_addr <= idx; cfg_wdata <= val[CFG_DATA_W-1:0];
    @(posedge clk);
  endtask

  // waits until every expected result has arrived, then lets the pipeline empty
  task automatic drain;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic setup(input int r, input int w, input int h, input int rs, input int cs);
    drain();
    write_reg(REG_RADIUS, r);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_ROW_STEP, rs);
    write_reg(REG_COL_STEP, cs);
    cfg_we <= 0;
  endtask

  // one pixel request; random gaps before it
  task automatic send_pixel(input logic [15:0] p);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1; s_tdata <= p;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_frame(input int n, input int mode);
    for (int k = 0; k < n; k++)
      case (mode)
        0: send_pixel(16'hFFFF);
        1: send_pixel(k[0] ? 16'h0000 : 16'hFFFF);
        default: send_pixel(16'($urandom_range(65535)));
      endcase
    s_tvalid <= 0;
  endtask

  int w, h;
  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: max window, all-ones pixels, max steps
    setup(3, 7, 8, 255, 255);
    send_frame(56, 0);
    // radius zero, single pixel frames and zero dims (treated as 1)
    setup(0, 0, 0, 0, 0);
    send_frame(3, 1);
    setup(1, 3, 3, 0, 255);
    send_frame(9, 1);
    setup(2, 5, 5, 128, 1);
    send_frame(25, 2);
    // random phases with differing flow control
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 69; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 69; end
        default: begin send_idle = 25; recv_stall = 25; end
      endcase
      w = $urandom_range(12, 1);
      h = $urandom_range(10, 1);
      if (ph == 5) begin w = 4096; h = 1; end      // widest row, a single row
      setup($urandom_range(3), w, h, $urandom_range(255), $urandom_range(255));
      if (ph == 5) send_frame(120, 2);
      else send_frame(w * h * $urandom_range(2, 1) + $urandom_range(5), 2);
    end
    // oversized dims saturate
    setup(1, 8191, 8191, 7, 9);
    send_frame(20, 2);
    drain();
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
